// ===== design/mexp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared types and constants for the modular exponentiation block.
// ----------------------------------------------------------------------------
package mexp_pkg;

  localparam int MOD_W  = 31;             // modulus and residue width
  localparam int BASE_W = 63;             // base and exponent field width
  localparam int SER_W  = 63;             // serial multiplier register width
  localparam int CNT_W  = 6;              // holds SER_W
  localparam int PAD_W  = SER_W - MOD_W;  // left-align pad for a residue

  localparam logic [MOD_W-1:0] MOD_RESET = 31'd998244353;
  localparam logic [CNT_W-1:0] NB_REDUCE = 6'd63;
  localparam logic [CNT_W-1:0] NB_MUL    = 6'd31;

  localparam logic OP_POWER   = 1'b0;
  localparam logic OP_INVERSE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_STEP,
    ST_MUL_ACC,
    ST_SQUARE,
    ST_FINISH
  } seq_state_t;

  // Request to the shared serial multiplier
  typedef struct packed {
    logic             start;
    logic [MOD_W-1:0] mcand;   // multiplicand, below the modulus
    logic [SER_W-1:0] mplier;  // multiplier, consumed from the top bit
    logic [CNT_W-1:0] nbits;   // number of multiplier bits to consume
  } mul_req_t;

  // Response from the shared serial multiplier
  typedef struct packed {
    logic             done;
    logic [MOD_W-1:0] product;
  } mul_rsp_t;

endpackage

// ===== design/mexp_modmul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_modmul
// Bit-serial modular multiplier: r = 2r + (bit ? mcand : 0) mod m per cycle,
// multiplier bits taken from the top. Also reduces a wide value mod m when
// the multiplicand is one.
// ----------------------------------------------------------------------------
module mexp_modmul (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [mexp_pkg::MOD_W-1:0] modulus,
  input  mexp_pkg::mul_req_t         req,
  output mexp_pkg::mul_rsp_t         rsp
);

  logic                       busy;
  logic                       done;
  logic [mexp_pkg::CNT_W-1:0] cnt;
  logic [mexp_pkg::MOD_W-1:0] r;
  logic [mexp_pkg::MOD_W-1:0] mcand;
  logic [mexp_pkg::SER_W-1:0] mplier;

  logic [mexp_pkg::MOD_W+1:0] t;
  logic [mexp_pkg::MOD_W+1:0] m1;
  logic [mexp_pkg::MOD_W+1:0] m2;
  logic [mexp_pkg::MOD_W+1:0] t_red;

  // Double, add, then bring back below the modulus (t < 3m)
  always_comb begin
    m1 = {2'b00, modulus};
    m2 = {1'b0, modulus, 1'b0};
    t  = {1'b0, r, 1'b0} + (mplier[mexp_pkg::SER_W-1] ? {2'b00, mcand} : '0);
    if (t >= m2) begin
      t_red = t - m2;
    end else if (t >= m1) begin
      t_red = t - m1;
    end else begin
      t_red = t;
    end
  end

  // Control: load on start, count down, pulse done after the last bit
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt  <= req.nbits;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == mexp_pkg::CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: accumulator and shifting multiplier
  always_ff @(posedge clk) begin
    if (req.start && !busy) begin
      r      <= '0;
      mcand  <= req.mcand;
      mplier <= req.mplier;
    end else if (busy) begin
      r      <= t_red[mexp_pkg::MOD_W-1:0];
      mplier <= {mplier[mexp_pkg::SER_W-2:0], 1'b0};
    end
  end

  assign rsp.done    = done;
  assign rsp.product = r;

endmodule

// ===== design/mexp_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_seq
// Square-and-multiply sequencer: reduces the base, walks the exponent from
// the low bit, drives the shared multiplier and holds the result register.
// ----------------------------------------------------------------------------
module mexp_seq #(
  parameter int EXP_BITS = 63
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [mexp_pkg::MOD_W-1:0]  modulus,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        opcode,
  input  logic [mexp_pkg::BASE_W-1:0] base,
  input  logic [mexp_pkg::BASE_W-1:0] exponent,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [mexp_pkg::MOD_W-1:0]  result,
  output mexp_pkg::mul_req_t          mul_req,
  input  mexp_pkg::mul_rsp_t          mul_rsp
);

  mexp_pkg::seq_state_t state;
  mexp_pkg::seq_state_t state_next;

  logic [mexp_pkg::MOD_W-1:0]  acc;
  logic [mexp_pkg::MOD_W-1:0]  run;
  logic [EXP_BITS-1:0]         ebits;
  logic [mexp_pkg::BASE_W-1:0] e_full;
  logic                        mod_small;
  logic                        in_xfer;
  logic                        out_load;

  assign mod_small = (modulus < mexp_pkg::MOD_W'(2));
  assign in_ready  = (state == mexp_pkg::ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_load  = (state == mexp_pkg::ST_FINISH) && (!out_valid || out_ready);

  // Inverse mode raises to modulus minus two
  assign e_full = (opcode == mexp_pkg::OP_INVERSE)
                ? {{(mexp_pkg::BASE_W-mexp_pkg::MOD_W){1'b0}}, modulus - mexp_pkg::MOD_W'(2)}
                : exponent;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mexp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and multiplier requests
  always_comb begin
    state_next     = state;
    mul_req.start  = 1'b0;
    mul_req.mcand  = run;
    mul_req.mplier = {run, {mexp_pkg::PAD_W{1'b0}}};
    mul_req.nbits  = mexp_pkg::NB_MUL;
    unique case (state)
      mexp_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (mod_small) begin
            state_next = mexp_pkg::ST_FINISH;
          end else begin
            mul_req.start  = 1'b1;
            mul_req.mcand  = mexp_pkg::MOD_W'(1);
            mul_req.mplier = base;
            mul_req.nbits  = mexp_pkg::NB_REDUCE;
            state_next     = mexp_pkg::ST_REDUCE;
          end
        end
      end
      mexp_pkg::ST_REDUCE: begin
        if (mul_rsp.done) begin
          state_next = mexp_pkg::ST_STEP;
        end
      end
      mexp_pkg::ST_STEP: begin
        if (ebits == '0) begin
          state_next = mexp_pkg::ST_FINISH;
        end else if (ebits[0]) begin
          mul_req.start = 1'b1;
          mul_req.mcand = acc;
          state_next    = mexp_pkg::ST_MUL_ACC;
        end else begin
          mul_req.start = 1'b1;
          state_next    = mexp_pkg::ST_SQUARE;
        end
      end
      mexp_pkg::ST_MUL_ACC: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          state_next    = mexp_pkg::ST_SQUARE;
        end
      end
      mexp_pkg::ST_SQUARE: begin
        if (mul_rsp.done) begin
          state_next = mexp_pkg::ST_STEP;
        end
      end
      mexp_pkg::ST_FINISH: begin
        if (!out_valid || out_ready) begin
          state_next = mexp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mexp_pkg::ST_IDLE;
      end
    endcase
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      acc   <= mod_small ? '0 : mexp_pkg::MOD_W'(1);
      ebits <= e_full[EXP_BITS-1:0];
    end
    if (state == mexp_pkg::ST_REDUCE && mul_rsp.done) begin
      run <= mul_rsp.product;
    end
    if (state == mexp_pkg::ST_MUL_ACC && mul_rsp.done) begin
      acc <= mul_rsp.product;
    end
    if (state == mexp_pkg::ST_SQUARE && mul_rsp.done) begin
      run   <= mul_rsp.product;
      ebits <= ebits >> 1;
    end
  end

  // Output register: hold until the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      result <= acc;
    end
  end

endmodule

// ===== design/modular_exponentiation_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation_top
// Modular power and Fermat inverse by right-to-left square and multiply.
// ----------------------------------------------------------------------------
// Channel   Dir  Content
// s_*       in   tuser[0] opcode; tdata[62:0] base, [125:63] exponent
// m_*       out  tdata[30:0] result
// modulus_* in   write enable and 31-bit modulus
//
// One item at a time. The base is reduced first; each exponent bit up to its
// highest set bit then takes a step state and a squaring, plus a multiply
// when the bit is set, all on the shared bit-serial multiplier.
// A modulus below two skips the multiplier and gives a result of zero. Reset is
// synchronous and restores the modulus to 998244353. A stalled result is held
// in the output register while the next item is taken.
// ----------------------------------------------------------------------------
module modular_exponentiation_top #(
  parameter int EXP_BITS = 63
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         modulus_we,
  input  logic [30:0]  modulus_wdata,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [127:0] s_tdata,   // base [62:0], exponent [125:63], zero pad
  input  logic [0:0]   s_tuser,   // opcode [0]
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [31:0]  m_tdata    // result [30:0], zero pad
);

  logic [mexp_pkg::MOD_W-1:0] modulus;
  logic [mexp_pkg::MOD_W-1:0] result;
  mexp_pkg::mul_req_t         mul_req;
  mexp_pkg::mul_rsp_t         mul_rsp;

  // Modulus register
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= mexp_pkg::MOD_RESET;
    end else if (modulus_we) begin
      modulus <= modulus_wdata;
    end
  end

  mexp_seq #(
    .EXP_BITS (EXP_BITS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .modulus   (modulus),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .opcode    (s_tuser[0]),
    .base      (s_tdata[62:0]),
    .exponent  (s_tdata[125:63]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .result    (result),
    .mul_req   (mul_req),
    .mul_rsp   (mul_rsp)
  );

  mexp_modmul u_modmul (
    .clk     (clk),
    .rst     (rst),
    .modulus (modulus),
    .req     (mul_req),
    .rsp     (mul_rsp)
  );

  assign m_tdata = {1'b0, result};

endmodule
